// File: hw/rtl/fbc_pkg.sv
package fbc_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned CFG_INDEX_W = 8;
    localparam int unsigned QUEUE_DEPTH = 4;

    localparam logic [BYTE_W-1:0]      CRC_POLY      = 8'h8C;
    localparam logic [CFG_INDEX_W-1:0] CFG_START     = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_OWN_ADDR  = 8'd1;

    // One classified input item as it travels from the front to the back.
    typedef struct packed {
        logic              first;
        logic              zero_len;
        logic              last;
        logic [BYTE_W-1:0] start_byte;
        logic [BYTE_W-1:0] own_address;
        logic [BYTE_W-1:0] destination;
        logic [BYTE_W-1:0] payload_length;
        logic [BYTE_W-1:0] data_byte;
    } t_cmd;

    // Reflected CRC-8 update by one byte, one bit per step.
    function automatic logic [BYTE_W-1:0] crc8_update(
        input logic [BYTE_W-1:0] crc,
        input logic [BYTE_W-1:0] data
    );
        logic [BYTE_W-1:0] c;
        c = crc ^ data;
        for (int k = 0; k < BYTE_W; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

// File: hw/rtl/fbc_if.sv
interface fbc_in_if
    import fbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] destination;
    logic [BYTE_W-1:0] payload_length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, output destination, output payload_length,
                    output data_byte, input ready);
    modport sink   (input valid, input destination, input payload_length,
                    input data_byte, output ready);
endinterface

interface fbc_out_if
    import fbc_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] tx_byte;
    logic              frame_end;
    logic              run_last;

    modport source (output valid, output tx_byte, output frame_end,
                    output run_last, input ready);
    modport sink   (input valid, input tx_byte, input frame_end,
                    input run_last, output ready);
endinterface

interface fbc_cfg_if
    import fbc_pkg::*;
();
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [BYTE_W-1:0]      data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// File: hw/rtl/fbc_front.sv
module fbc_front
    import fbc_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    fbc_in_if.sink   i_in,
    fbc_cfg_if.sink  i_cfg,
    input  logic     i_full,
    output logic     o_push,
    output t_cmd     o_cmd
);

    logic [BYTE_W-1:0] r_start_byte;
    logic [BYTE_W-1:0] r_own_address;
    logic              r_in_frame;
    logic [BYTE_W-1:0] r_bytes_left;
    logic              n_in_frame;
    logic [BYTE_W-1:0] n_bytes_left;
    logic              accept;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = !i_full;
    assign accept      = i_in.valid && !i_full;
    assign o_push      = accept;

    always_comb begin
        o_cmd.start_byte     = r_start_byte;
        o_cmd.own_address    = r_own_address;
        o_cmd.destination    = i_in.destination;
        o_cmd.payload_length = i_in.payload_length;
        o_cmd.data_byte      = i_in.data_byte;
        o_cmd.first          = !r_in_frame;
        o_cmd.zero_len       = 1'b0;
        if (!r_in_frame) begin
            o_cmd.zero_len = (i_in.payload_length == '0);
            o_cmd.last     = (i_in.payload_length == BYTE_W'(1));
            n_bytes_left   = i_in.payload_length - BYTE_W'(1);
            n_in_frame     = (i_in.payload_length > BYTE_W'(1));
        end else begin
            o_cmd.last     = (r_bytes_left == BYTE_W'(1));
            n_bytes_left   = r_bytes_left - BYTE_W'(1);
            n_in_frame     = (r_bytes_left != BYTE_W'(1));
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_byte  <= '0;
            r_own_address <= '0;
            r_in_frame    <= 1'b0;
            r_bytes_left  <= '0;
        end else begin
            if (i_cfg.valid) begin
                if (i_cfg.index == CFG_START) begin
                    r_start_byte <= i_cfg.data;
                end else if (i_cfg.index == CFG_OWN_ADDR) begin
                    r_own_address <= i_cfg.data;
                end
            end
            if (accept) begin
                r_in_frame   <= n_in_frame;
                r_bytes_left <= n_bytes_left;
            end
        end
    end

endmodule

// File: hw/rtl/fbc_queue.sv
module fbc_queue
    import fbc_pkg::*;
#(
    parameter int unsigned DEPTH = QUEUE_DEPTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    output logic o_head_valid,
    output t_cmd o_head,
    input  logic i_pop
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full       = (r_count == CNT_W'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

endmodule

// File: hw/rtl/fbc_back.sv
module fbc_back
    import fbc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_head_valid,
    input  t_cmd      i_head,
    output logic      o_pop,
    fbc_out_if.source o_out
);

    localparam logic [2:0] ST_START = 3'd0;
    localparam logic [2:0] ST_DEST  = 3'd1;
    localparam logic [2:0] ST_SRC   = 3'd2;
    localparam logic [2:0] ST_LEN   = 3'd3;
    localparam logic [2:0] ST_DATA  = 3'd4;
    localparam logic [2:0] ST_CRC   = 3'd5;

    logic              r_started;
    logic [2:0]        r_step;
    logic [BYTE_W-1:0] r_crc;
    logic              r_valid;
    logic [BYTE_W-1:0] r_tx_byte;
    logic              r_frame_end;
    logic              r_run_last;

    logic [2:0]        cur_step;
    logic [2:0]        n_step;
    logic [BYTE_W-1:0] n_byte;
    logic [BYTE_W-1:0] n_crc;
    logic              done;
    logic              fire;

    assign o_out.valid     = r_valid;
    assign o_out.tx_byte   = r_tx_byte;
    assign o_out.frame_end = r_frame_end;
    assign o_out.run_last  = r_run_last;

    // The output register is free when empty or when its transfer completes now.
    assign fire  = i_head_valid && (!r_valid || o_out.ready);
    assign o_pop = fire && done;

    always_comb begin
        cur_step = r_started ? r_step : (i_head.first ? ST_START : ST_DATA);
        n_step   = ST_CRC;
        n_byte   = r_crc;
        n_crc    = r_crc;
        done     = 1'b0;
        case (cur_step)
            ST_START: begin
                n_byte = i_head.start_byte;
                n_step = ST_DEST;
                n_crc  = '0;
            end
            ST_DEST: begin
                n_byte = i_head.destination;
                n_step = ST_SRC;
                n_crc  = crc8_update(r_crc, i_head.destination);
            end
            ST_SRC: begin
                n_byte = i_head.own_address;
                n_step = ST_LEN;
                n_crc  = crc8_update(r_crc, i_head.own_address);
            end
            ST_LEN: begin
                n_byte = i_head.payload_length;
                n_step = i_head.zero_len ? ST_CRC : ST_DATA;
            end
            ST_DATA: begin
                n_byte = i_head.data_byte;
                n_step = ST_CRC;
                n_crc  = crc8_update(r_crc, i_head.data_byte);
                done   = !i_head.last;
            end
            default: begin
                n_byte = r_crc;
                n_crc  = '0;
                done   = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_tx_byte   <= n_byte;
            r_frame_end <= (cur_step == ST_CRC);
            r_run_last  <= done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_started <= 1'b0;
            r_step    <= ST_START;
            r_crc     <= '0;
            r_valid   <= 1'b0;
        end else begin
            if (fire) begin
                r_valid   <= 1'b1;
                r_crc     <= n_crc;
                r_started <= !done;
                r_step    <= n_step;
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    // A partly emitted item stays at the head of the queue until its last byte.
    a_started_has_head: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_started |-> i_head_valid)
        else $error("back is mid-item with an empty queue");

    a_crc_ends_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_frame_end) |-> r_run_last)
        else $error("CRC byte not marked as last result of its item");

    a_crc_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fire && cur_step == ST_CRC) |=> (r_crc == '0) && !r_started)
        else $error("running CRC not cleared after the check byte");

endmodule

// File: hw/rtl/frame_builder_with_crc8.sv
// The first result of an item passes through the command queue and the output register.
// Throughput: items are taken one per cycle while the command queue has room.
// The back emits one frame byte per cycle while the output is ready: a message's first
// item gives start, destination, source and length, then its data byte unless the length
// is zero; each later item gives its byte; the item that ends the message adds the CRC.
// Reset (synchronous, active low) clears both registers, the frame state and the queue.
module frame_builder_with_crc8
    import fbc_pkg::*;
#(
    parameter int unsigned QDEPTH = QUEUE_DEPTH
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    fbc_in_if.sink    i_in,
    fbc_cfg_if.sink   i_cfg,
    fbc_out_if.source o_out
);

    logic push;
    logic full;
    logic pop;
    logic head_valid;
    t_cmd cmd;
    t_cmd head;

    fbc_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cfg   (i_cfg),
        .i_full  (full),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    fbc_queue #(
        .DEPTH (QDEPTH)
    ) u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .i_cmd        (cmd),
        .o_full       (full),
        .o_head_valid (head_valid),
        .o_head       (head),
        .i_pop        (pop)
    );

    fbc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (pop),
        .o_out        (o_out)
    );

endmodule
